/* hw/rtl/cdip_pkg.sv */
// cdip_pkg: shared constants for the checked decimal integer parser
// holds character codes, parse phase codes, register indexes and field widths
// no dependencies
package cdip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam int unsigned PHASE_W = 2;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [PHASE_W-1:0]    phase_t;

  // character codes
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;

  // parse phases
  localparam phase_t PH_START  = 2'd0;
  localparam phase_t PH_SIGN   = 2'd1;
  localparam phase_t PH_DIGITS = 2'd2;
  localparam phase_t PH_STOP   = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t REG_SIGNED_MODE  = 1'd0;
  localparam cfg_idx_t REG_LENIENT_MODE = 1'd1;

endpackage

/* hw/rtl/cdip_char_if.sv */
// cdip_char_if and cdip_result_if: valid/ready channels of the parser
// character requests in, parsed results out
// depends on cdip_pkg
interface cdip_char_if;
  logic               valid;
  logic               ready;
  cdip_pkg::char_t    char_code;
  logic               last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cdip_result_if;
  logic               valid;
  logic               ready;
  cdip_pkg::value_t   parsed_value;
  logic               parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink   (input valid, input parsed_value, input parse_ok, output ready);
endinterface

/* hw/rtl/checked_decimal_integer_parser.sv */
// checked_decimal_integer_parser: decimal text to WIDTH-bit integer, with overflow check
// depends on cdip_pkg, cdip_char_if and cdip_result_if
//
//   channel   dir   payload                     request moves
//   chars     in    char_code[7:0], last_char   one character
//   result    out   parsed_value[31:0], parse_ok one number, on the last character
//   cfg       in    cfg_we, cfg_index, cfg_data one register write
//
// one character per cycle while chars.ready is high; each is folded into the
// accumulator by a multiply-by-ten (shift and add) and a limit compare in a single stage.
// the result is loaded into an output register when the last character is accepted.
// chars.ready drops only while the output register holds an untaken result.
// rst (synchronous) clears the parse state and sets signed_mode=1, lenient_mode=0.
module checked_decimal_integer_parser #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  cdip_char_if.sink           chars,
  cdip_result_if.source       result,
  input  logic                cfg_we,
  input  cdip_pkg::cfg_idx_t  cfg_index,
  input  cdip_pkg::cfg_data_t cfg_data
);
  import cdip_pkg::*;

  localparam logic [WIDTH-1:0] UMAX = {WIDTH{1'b1}};
  localparam logic [WIDTH-1:0] SMAX = UMAX >> 1;
  localparam logic [WIDTH-1:0] Q_U  = UMAX / 10;
  localparam logic [WIDTH-1:0] Q_S  = SMAX / 10;
  localparam logic [3:0]       R_U  = 4'(UMAX % 10);
  localparam logic [3:0]       R_S  = 4'(SMAX % 10);

  logic             signed_mode;
  logic             lenient_mode;

  logic [WIDTH-1:0] acc;
  logic             minus;
  phase_t           phase;
  logic             err;

  logic [WIDTH-1:0] acc_next;
  logic             minus_next;
  phase_t           phase_next;
  logic             err_next;

  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [WIDTH-1:0] acc_x10;
  logic [WIDTH-1:0] acc_step;
  logic [WIDTH-1:0] lim_q;
  logic [3:0]       lim_r;
  logic             over;
  logic             ok_next;
  logic [WIDTH-1:0] mag_signed;
  value_t           value_next;

  assign chars.ready = !result.valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  assign is_digit = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
  assign digit    = chars.char_code[3:0];
  assign acc_x10  = (acc << 3) + (acc << 1);
  assign acc_step = acc_x10 + WIDTH'(digit);

  assign lim_q = signed_mode ? Q_S : Q_U;
  assign lim_r = signed_mode ? (R_S + 4'(minus)) : R_U;
  assign over  = (acc > lim_q) || ((acc == lim_q) && (digit > lim_r));

  always_comb begin
    acc_next   = acc;
    minus_next = minus;
    phase_next = phase;
    err_next   = err;
    unique case (phase)
      PH_START, PH_SIGN, PH_DIGITS: begin
        if (phase == PH_START && chars.char_code == CH_PLUS) begin
          phase_next = PH_SIGN;
        end else if (phase == PH_START && chars.char_code == CH_MINUS && signed_mode) begin
          minus_next = 1'b1;
          phase_next = PH_SIGN;
        end else if (is_digit) begin
          if (!lenient_mode && over) begin
            err_next   = 1'b1;
            phase_next = PH_STOP;
          end else begin
            acc_next   = acc_step;
            phase_next = PH_DIGITS;
          end
        end else begin
          // first non-digit: lenient stops quietly, checked fails
          if (!lenient_mode) err_next = 1'b1;
          phase_next = PH_STOP;
        end
      end
      PH_STOP: begin
        if (!lenient_mode) err_next = 1'b1;
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  assign ok_next    = lenient_mode || (!err_next && phase_next == PH_DIGITS);
  assign mag_signed = minus_next ? (WIDTH'(0) - acc_next) : acc_next;
  assign value_next = ok_next ? VALUE_W'(mag_signed) : '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode  <= 1'b1;
      lenient_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIGNED_MODE:  signed_mode  <= cfg_data[0];
        REG_LENIENT_MODE: lenient_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // parse state, cleared after each last character
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      minus <= 1'b0;
      phase <= PH_START;
      err   <= 1'b0;
    end else if (accept) begin
      if (chars.last_char) begin
        acc   <= '0;
        minus <= 1'b0;
        phase <= PH_START;
        err   <= 1'b0;
      end else begin
        acc   <= acc_next;
        minus <= minus_next;
        phase <= phase_next;
        err   <= err_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && chars.last_char) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.last_char) begin
      result.parsed_value <= value_next;
      result.parse_ok     <= ok_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> result.valid)
    else $error("input stalled with empty output register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && chars.last_char |=> result.valid && phase == PH_START)
    else $error("last character did not produce a result or clear state");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.parse_ok |-> result.parsed_value == '0)
    else $error("failed parse carries a nonzero value");

  a_start_is_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> acc == '0 && !minus && !err)
    else $error("start phase with leftover string state");

  a_sign_has_no_digits: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SIGN |-> acc == '0 && !err)
    else $error("sign phase with accumulated digits or error");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for checked_decimal_integer_parser
// streams character requests, predicts each number, checks the results
// depends on cdip_pkg, cdip_char_if, cdip_result_if and the parser rtl
module tb;
  import cdip_pkg::*;

  localparam int unsigned W = 32;

  // predicts the parse of each character stream and holds the numbers due
  class parse_scoreboard;
    bit          signed_mode;
    bit          lenient_mode;
    logic [63:0] acc;
    bit          minus;
    phase_t      phase;
    bit          failed;
    value_t      want_value[$];
    bit          want_ok[$];
    int          errors;

    function new();
      signed_mode  = 1'b1;
      lenient_mode = 1'b0;
      errors       = 0;
      clear();
    endfunction

    function void clear();
      acc    = '0;
      minus  = 1'b0;
      phase  = PH_START;
      failed = 1'b0;
    endfunction

    function logic [63:0] width_ones();
      return (W >= 64) ? '1 : ((64'd1 << W) - 64'd1);
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        REG_SIGNED_MODE:  signed_mode  = val[0];
        REG_LENIENT_MODE: lenient_mode = val[0];
        default: ;
      endcase
    endfunction

    function void fold_digit(logic [63:0] d);
      logic [63:0] lim, q, r;
      if (lenient_mode) begin
        acc   = (acc * 64'd10 + d) & width_ones();
        phase = PH_DIGITS;
        return;
      end
      lim = signed_mode ? (width_ones() >> 1) : width_ones();
      q   = lim / 64'd10;
      r   = lim % 64'd10;
      if (signed_mode && minus) r = r + 64'd1;
      if (acc > q || (acc == q && d > r)) begin
        failed = 1'b1;
        phase  = PH_STOP;
        return;
      end
      acc   = acc * 64'd10 + d;
      phase = PH_DIGITS;
    endfunction

    function void stop_here();
      if (!lenient_mode) failed = 1'b1;
      phase = PH_STOP;
    endfunction

    function void note_char(char_t c, logic is_last);
      bit          is_digit;
      logic [63:0] v;
      bit          ok;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (phase)
        PH_START: begin
          if (c == CH_PLUS) begin
            phase = PH_SIGN;
          end else if (c == CH_MINUS && signed_mode) begin
            minus = 1'b1;
            phase = PH_SIGN;
          end else if (is_digit) begin
            fold_digit(64'(c) - 64'(CH_ZERO));
          end else begin
            stop_here();
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) fold_digit(64'(c) - 64'(CH_ZERO));
          else stop_here();
        end
        default: begin
          if (!lenient_mode) failed = 1'b1;
        end
      endcase
      if (is_last !== 1'b1) return;
      v  = minus ? ((64'd0 - acc) & width_ones()) : (acc & width_ones());
      ok = lenient_mode || (!failed && phase == PH_DIGITS);
      if (!ok) v = '0;
      want_value.push_back(v[31:0]);
      want_ok.push_back(ok);
      clear();
    endfunction

    function void check_result(value_t v, logic ok);
      value_t ev;
      bit     eok;
      if (want_value.size() == 0) begin
        $error("unexpected result parsed_value=%h parse_ok=%b", v, ok);
        errors++;
        return;
      end
      ev  = want_value.pop_front();
      eok = want_ok.pop_front();
      if (v !== ev) begin
        $error("parsed_value expected %h actual %h", ev, v);
        errors++;
      end
      if (ok !== eok) begin
        $error("parse_ok expected %b actual %b", eok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return want_value.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  cdip_char_if   chars_if ();
  cdip_result_if result_if ();

  checked_decimal_integer_parser #(.WIDTH(W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  parse_scoreboard sb = new();

  char_t num_text[$];
  int    items_sent;
  bit    send_stalls;
  bit    sink_stalls;
  bit    hold_request;

  always #4 clk = ~clk;

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (chars_if.valid && chars_if.ready)
        sb.note_char(chars_if.char_code, chars_if.last_char);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.parsed_value, result_if.parse_ok);
    end
  end

  // result side: random short gaps, rare long ones, and one long hold-off
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 299;
        result_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        result_if.ready <= 1'b0;
        gap_left--;
      end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
        gap_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  function automatic void load_str(string s);
    num_text.delete();
    for (int i = 0; i < s.len(); i++) num_text.push_back(char_t'(s[i]));
  endfunction

  function automatic void append_decimal(logic [63:0] v);
    char_t digits[$];
    do begin
      digits.push_front(CH_ZERO + char_t'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digits[i]) num_text.push_back(digits[i]);
  endfunction

  // values around the signed and unsigned overflow limits, plus zero and a ten-digit overflow
  function automatic logic [63:0] near_limit();
    logic [63:0] base;
    int          d;
    case ($urandom_range(0, 6))
      0:       base = 64'd214748364;
      1:       base = 64'd2147483647;
      2:       base = 64'd2147483648;
      3:       base = 64'd4294967295;
      4:       base = 64'd429496729;
      5:       base = 64'd9999999999;
      default: base = 64'd0;
    endcase
    d = int'($urandom_range(0, 6)) - 3;
    if (d < 0 && base < 64'(-d)) return base;
    return base + 64'(signed'(d));
  endfunction

  function automatic void build_text();
    int kind;
    int n;
    num_text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      case ($urandom_range(0, 9))
        0, 1:    num_text.push_back(CH_PLUS);
        2, 3, 4: num_text.push_back(CH_MINUS);
        default: ;
      endcase
      if (kind >= 75) begin
        // sign with no digits
        if (num_text.size() == 0) num_text.push_back(CH_MINUS);
        if ($urandom_range(0, 2) == 0) num_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      end else begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 3)) num_text.push_back(CH_ZERO);
        if ($urandom_range(0, 1)) begin
          append_decimal(near_limit());
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) num_text.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
        end
        if (kind >= 60) begin
          if ($urandom_range(0, 1))
            num_text.push_back(char_t'($urandom_range(0, 255)));
          else
            num_text.insert($urandom_range(0, num_text.size() - 1), char_t'($urandom_range(0, 255)));
        end
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0, 1:    num_text.push_back(char_t'($urandom_range(0, 255)));
          2:       num_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          default: num_text.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
        endcase
      end
    end
  endfunction

  task automatic send_char(char_t c, bit is_last);
    int n;
    if (send_stalls && $urandom_range(0, 99) < 20) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      @(negedge clk);
      chars_if.valid     <= 1'b0;
      chars_if.char_code <= char_t'($urandom);
      chars_if.last_char <= 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.last_char <= is_last;
    do @(posedge clk); while (!chars_if.ready);
    items_sent++;
  endtask

  task automatic send_text(bit close);
    foreach (num_text[i]) send_char(num_text[i], close && (i == num_text.size() - 1));
  endtask

  task automatic drain();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    bit [1:0] modes [4];
    int       start;
    modes = '{2'b00, 2'b11, 2'b01, 2'b10};
    items_sent   = 0;
    send_stalls  = 1'b0;
    sink_stalls  = 1'b0;
    hold_request = 1'b0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SIGNED_MODE;
    cfg_data           <= '0;
    chars_if.valid     <= 1'b0;
    chars_if.char_code <= '0;
    chars_if.last_char <= 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed strings under the reset modes: signed, checked
    load_str("-");
    send_text(1'b1);
    load_str("+7");
    send_text(1'b1);
    load_str("1x");
    send_text(1'b1);
    num_text = '{8'hFF};
    send_text(1'b1);
    load_str("2147483648");
    send_text(1'b1);
    load_str("0");
    send_text(1'b1);
    // switch to lenient in the middle of a negative number
    load_str("-12");
    send_text(1'b0);
    drain();
    write_reg(REG_LENIENT_MODE, 1'b1);
    load_str("3");
    send_text(1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SIGNED_MODE, modes[p][1]);
      write_reg(REG_LENIENT_MODE, modes[p][0]);
      start = items_sent;
      // long result hold-off while characters keep coming
      if (p == 1) hold_request = 1'b1;
      while (items_sent - start < 400) begin
        if ($urandom_range(0, 29) == 0) begin
          send_stalls = ($urandom_range(0, 3) != 0);
          sink_stalls = ($urandom_range(0, 3) != 0);
        end
        build_text();
        send_text(1'b1);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/cdip_pkg.sv
hw/rtl/cdip_char_if.sv
hw/rtl/checked_decimal_integer_parser.sv
tb/tb.sv
